### rtl/fdt_pkg.sv
// shared constants, codes and types of the foreign device table
package fdt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int GRACE_SECONDS = 30;
    localparam int RESULT_LIMIT  = 16;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_REGISTER   = 3'd1;
    localparam logic [2:0] OP_UNREGISTER = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_DISTRIBUTE = 3'd4;

    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_REG_NAK   = 3'd1;
    localparam logic [2:0] RC_DEL_NAK   = 3'd2;
    localparam logic [2:0] RC_FULL      = 3'd3;
    localparam logic [2:0] RC_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [23:0] vaddr;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [15:0] port;
        logic [16:0] lifetime;
        logic [31:0] stamp;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic tick;
        logic scan;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_tick;
        logic in_scan;
        logic in_direct;
        logic last_slot;
        logic scan_hold;
        logic out_free;
    } t_stat;

endpackage

### rtl/fdt_ctrl.sv
// control state machine of the foreign device table
module fdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fdt_pkg::t_stat i_stat,
    output fdt_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.tick   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = accept;
                o_cmd.tick = accept && i_stat.in_tick;
                if (accept && i_stat.in_scan) begin
                    n_state = ST_SCAN;
                end else if (accept && i_stat.in_direct) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = !i_stat.scan_hold;
                if (!i_stat.scan_hold && i_stat.last_slot) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/fdt_datapath.sv
// table storage, slot scan and result register of the foreign device table
module fdt_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic [2:0]     i_operation,
    input  logic [23:0]    i_virtual_address,
    input  logic [63:0]    i_addr_high,
    input  logic [63:0]    i_addr_low,
    input  logic [15:0]    i_port,
    input  logic [15:0]    i_time_to_live,
    input  logic           i_out_stall,
    input  fdt_pkg::t_cmd  i_cmd,
    output fdt_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic [2:0]     o_result_code,
    output logic           o_is_member,
    output logic           o_entry_present,
    output logic [63:0]    o_dest_addr_high,
    output logic [63:0]    o_dest_addr_low,
    output logic [15:0]    o_dest_port,
    output logic           o_last
);

    localparam int TE = fdt_pkg::TABLE_ENTRIES;
    localparam int IW = fdt_pkg::IDX_W;
    localparam int CW = fdt_pkg::CNT_W;

    // configuration and time
    logic        r_enable;
    logic [31:0] r_seconds;

    // table
    logic [TE-1:0]  r_valid;
    fdt_pkg::t_entry r_tab [TE];

    // captured item
    logic [2:0]  r_op;
    logic [23:0] r_va;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [15:0] r_port;
    logic [15:0] r_ttl;

    // scan state
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic          r_match_found;
    logic [IW-1:0] r_match_idx;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_member;
    logic          r_pend_valid;
    logic [63:0]   r_pend_hi;
    logic [63:0]   r_pend_lo;
    logic [15:0]   r_pend_port;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_out_code;
    logic        r_out_member;
    logic        r_out_present;
    logic [63:0] r_out_hi;
    logic [63:0] r_out_lo;
    logic [15:0] r_out_port;
    logic        r_out_last;

    logic        n_out_valid;
    logic [2:0]  n_out_code;
    logic        n_out_member;
    logic        n_out_present;
    logic [63:0] n_out_hi;
    logic [63:0] n_out_lo;
    logic [15:0] n_out_port;
    logic        n_out_last;

    // current slot
    fdt_pkg::t_entry cur;
    logic            cur_valid;
    logic [31:0]     cur_age;
    logic            cur_live;
    logic            cur_va_eq;
    logic            hit_match;
    logic            hit_free;
    logic            hit_query;
    logic            hit_dist;
    logic            out_free;
    logic            emit_pend;

    // table updates
    logic            wr_en;
    logic [IW-1:0]   wr_idx;
    fdt_pkg::t_entry wr_entry;
    logic            clr_en;

    assign cur       = r_tab[r_idx];
    assign cur_valid = r_valid[r_idx];
    assign cur_age   = r_seconds - cur.stamp;
    assign cur_live  = cur_valid && (cur_age < {15'd0, cur.lifetime});
    assign cur_va_eq = (cur.vaddr == r_va);

    always_comb begin
        if (r_op == fdt_pkg::OP_REGISTER) begin
            hit_match = cur_valid && cur_va_eq;
        end else begin
            hit_match = cur_valid && cur_va_eq && (cur.ip_high == r_hi)
                        && (cur.ip_low == r_lo) && (cur.port == r_port);
        end
    end

    assign hit_free  = !cur_live;
    assign hit_query = cur_live && cur_va_eq;
    assign hit_dist  = (r_op == fdt_pkg::OP_DISTRIBUTE) && cur_live && !cur_va_eq
                       && (r_cnt < CW'(fdt_pkg::RESULT_LIMIT));

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_pend = i_cmd.scan && hit_dist && r_pend_valid;

    always_comb begin
        o_stat.in_tick   = (i_operation == fdt_pkg::OP_TICK);
        o_stat.in_scan   = (((i_operation == fdt_pkg::OP_REGISTER)
                             || (i_operation == fdt_pkg::OP_UNREGISTER)) && r_enable)
                           || (i_operation == fdt_pkg::OP_QUERY)
                           || (i_operation == fdt_pkg::OP_DISTRIBUTE);
        o_stat.in_direct = ((i_operation == fdt_pkg::OP_REGISTER)
                            || (i_operation == fdt_pkg::OP_UNREGISTER)) && !r_enable;
        o_stat.last_slot = (r_idx == IW'(TE - 1));
        o_stat.scan_hold = hit_dist && r_pend_valid && !out_free;
        o_stat.out_free  = out_free;
    end

    // result selection and table update decisions
    always_comb begin
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_code    = r_out_code;
        n_out_member  = r_out_member;
        n_out_present = r_out_present;
        n_out_hi      = r_out_hi;
        n_out_lo      = r_out_lo;
        n_out_port    = r_out_port;
        n_out_last    = r_out_last;

        wr_en             = 1'b0;
        wr_idx            = r_match_idx;
        wr_entry.vaddr    = r_va;
        wr_entry.ip_high  = r_hi;
        wr_entry.ip_low   = r_lo;
        wr_entry.port     = r_port;
        wr_entry.lifetime = {1'b0, r_ttl} + 17'(fdt_pkg::GRACE_SECONDS);
        wr_entry.stamp    = r_seconds;
        clr_en            = 1'b0;

        if (emit_pend) begin
            n_out_valid   = 1'b1;
            n_out_code    = fdt_pkg::RC_OK;
            n_out_member  = 1'b0;
            n_out_present = 1'b1;
            n_out_hi      = r_pend_hi;
            n_out_lo      = r_pend_lo;
            n_out_port    = r_pend_port;
            n_out_last    = 1'b0;
        end else if (i_cmd.finish) begin
            n_out_valid   = 1'b1;
            n_out_code    = fdt_pkg::RC_OK;
            n_out_member  = 1'b0;
            n_out_present = 1'b0;
            n_out_hi      = '0;
            n_out_lo      = '0;
            n_out_port    = '0;
            n_out_last    = 1'b1;
            unique case (r_op)
                fdt_pkg::OP_REGISTER: begin
                    if (!r_enable) begin
                        n_out_code = fdt_pkg::RC_REG_NAK;
                    end else if (r_match_found) begin
                        wr_en = 1'b1;
                    end else if (r_free_found) begin
                        wr_en  = 1'b1;
                        wr_idx = r_free_idx;
                    end else begin
                        n_out_code = fdt_pkg::RC_FULL;
                    end
                end
                fdt_pkg::OP_UNREGISTER: begin
                    if (!r_enable) begin
                        n_out_code = fdt_pkg::RC_DEL_NAK;
                    end else if (r_match_found) begin
                        clr_en = 1'b1;
                    end else begin
                        n_out_code = fdt_pkg::RC_NOT_FOUND;
                    end
                end
                fdt_pkg::OP_QUERY: begin
                    n_out_member = r_member;
                end
                fdt_pkg::OP_DISTRIBUTE: begin
                    if (r_pend_valid) begin
                        n_out_present = 1'b1;
                        n_out_hi      = r_pend_hi;
                        n_out_lo      = r_pend_lo;
                        n_out_port    = r_pend_port;
                    end
                end
                default: begin
                    n_out_code = fdt_pkg::RC_OK;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_seconds    <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (i_cmd.tick) begin
                r_seconds <= r_seconds + 32'd1;
            end
            if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end else if (clr_en) begin
                r_valid[r_match_idx] <= 1'b0;
            end
            r_out_valid <= n_out_valid;
            if (i_cmd.load) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.scan && hit_dist) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    // table contents
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tab[wr_idx] <= wr_entry;
        end
    end

    // item capture and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op          <= i_operation;
            r_va          <= i_virtual_address;
            r_hi          <= i_addr_high;
            r_lo          <= i_addr_low;
            r_port        <= i_port;
            r_ttl         <= i_time_to_live;
            r_idx         <= '0;
            r_cnt         <= '0;
            r_match_found <= 1'b0;
            r_match_idx   <= '0;
            r_free_found  <= 1'b0;
            r_free_idx    <= '0;
            r_member      <= 1'b0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + IW'(1);
            if (hit_match && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_idx;
            end
            if (hit_free && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
            if (hit_query) begin
                r_member <= 1'b1;
            end
            if (hit_dist) begin
                r_cnt       <= r_cnt + CW'(1);
                r_pend_hi   <= cur.ip_high;
                r_pend_lo   <= cur.ip_low;
                r_pend_port <= cur.port;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_code    <= n_out_code;
        r_out_member  <= n_out_member;
        r_out_present <= n_out_present;
        r_out_hi      <= n_out_hi;
        r_out_lo      <= n_out_lo;
        r_out_port    <= n_out_port;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_code    = r_out_code;
    assign o_is_member      = r_out_member;
    assign o_entry_present  = r_out_present;
    assign o_dest_addr_high = r_out_hi;
    assign o_dest_addr_low  = r_out_lo;
    assign o_dest_port      = r_out_port;
    assign o_last           = r_out_last;

endmodule

### rtl/foreign_device_table.sv
// top level of the foreign device table
//
// foreign device table of a bacnet/ipv6 broadcast manager, 16 slots. a tick item
// advances the seconds counter and gives no result. register, unregister, query
// and distribute each scan the table one slot per cycle, except while a
// distribute result waits for the result side, so such an item stalls the input
// through the scan of all 16 slots and the finish step, and longer while the
// result side stalls. register and unregister while registrations are
// disabled skip the scan and answer with a nak. distribute gives one result per
// live slot whose virtual address differs from the source (at most 16, the
// final one marked last), or one empty result marked last. register, unregister
// and query each give one result; unused operation codes are dropped. slot
// valid bits clear at reset; no clearing pass is needed. the result sits in an
// output register, so a new item is taken while a result waits.
module foreign_device_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: accept registrations
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // input item
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [23:0] i_virtual_address,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [15:0] i_port,
    input  logic [15:0] i_time_to_live,
    // result item
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_code,
    output logic        o_is_member,
    output logic        o_entry_present,
    output logic [63:0] o_dest_addr_high,
    output logic [63:0] o_dest_addr_low,
    output logic [15:0] o_dest_port,
    output logic        o_last
);

    fdt_pkg::t_cmd  cmd;
    fdt_pkg::t_stat stat;

    // sequencing: idle, slot scan, final result
    fdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table, scan accumulators and result register
    fdt_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_operation       (i_operation),
        .i_virtual_address (i_virtual_address),
        .i_addr_high       (i_addr_high),
        .i_addr_low        (i_addr_low),
        .i_port            (i_port),
        .i_time_to_live    (i_time_to_live),
        .i_out_stall       (i_out_stall),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_result_code     (o_result_code),
        .o_is_member       (o_is_member),
        .o_entry_present   (o_entry_present),
        .o_dest_addr_high  (o_dest_addr_high),
        .o_dest_addr_low   (o_dest_addr_low),
        .o_dest_port       (o_dest_port),
        .o_last            (o_last)
    );

endmodule

### rtl/fdt_checker.sv
// port-level assertions of the foreign device table and their bind
module fdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_result_code,
    input logic        o_is_member,
    input logic        o_entry_present,
    input logic [63:0] o_dest_addr_high,
    input logic [63:0] o_dest_addr_low,
    input logic [15:0] o_dest_port,
    input logic        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_code)
            && $stable(o_last) && $stable(o_dest_addr_high) && $stable(o_dest_port))
        else $error("stalled result changed");

    // a destination result is always ok and never a membership answer
    a_dest_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_present |-> o_result_code == fdt_pkg::RC_OK && !o_is_member)
        else $error("destination with bad code");

    // results without a destination carry zero destination fields
    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_present |-> o_dest_addr_high == 64'd0
            && o_dest_addr_low == 64'd0 && o_dest_port == 16'd0)
        else $error("stray destination fields");

    // only distribute destinations can be followed by more results of the item
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_entry_present)
        else $error("non-final result without destination");

    // membership answers only come with an ok code, as the final result
    a_member_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_member |-> o_result_code == fdt_pkg::RC_OK && o_last)
        else $error("membership with bad code");

endmodule

bind foreign_device_table fdt_checker u_fdt_checker (.*);

### bench/foreign_device_table_test.sv
// testbench of the foreign device table: random and directed items checked against a predictor
module foreign_device_table_test;

    // operation codes the block drops without a result
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int POOL_SIZE     = 24;   // known devices, more than the table holds
    localparam int SETTLE_CYCLES = 24;   // one full scan plus margin
    localparam int IDLE_LIMIT    = 4000; // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 150;  // long receiver hold-off

    typedef struct packed {
        logic [2:0]  code;
        logic        member;
        logic        present;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] dport;
        logic        last;
    } t_reply;

    // mirror of the device table plus the queue of replies it predicts
    class t_reply_board;
        bit          accepting;
        logic [31:0] seconds_now;
        bit          used     [fdt_pkg::TABLE_ENTRIES];
        logic [23:0] vaddr    [fdt_pkg::TABLE_ENTRIES];
        logic [63:0] ip_high  [fdt_pkg::TABLE_ENTRIES];
        logic [63:0] ip_low   [fdt_pkg::TABLE_ENTRIES];
        logic [15:0] udp_port [fdt_pkg::TABLE_ENTRIES];
        logic [16:0] lifetime [fdt_pkg::TABLE_ENTRIES];
        logic [31:0] stamp    [fdt_pkg::TABLE_ENTRIES];
        t_reply      awaited_replies [$];
        int          errors;

        function new();
            accepting   = 1'b0;
            seconds_now = '0;
            errors      = 0;
            foreach (used[s]) begin
                used[s]     = 1'b0;
                vaddr[s]    = '0;
                ip_high[s]  = '0;
                ip_low[s]   = '0;
                udp_port[s] = '0;
                lifetime[s] = '0;
                stamp[s]    = '0;
            end
        endfunction

        // live: registered and age still below the stored lifetime
        function bit is_live(int s);
            logic [31:0] age;
            age = seconds_now - stamp[s];
            return used[s] && (age < {15'd0, lifetime[s]});
        endfunction

        function void await_reply(logic [2:0] code, bit member, bit present,
                                  logic [63:0] hi, logic [63:0] lo, logic [15:0] prt,
                                  bit last);
            t_reply r;
            r.code    = code;
            r.member  = member;
            r.present = present;
            r.hi      = hi;
            r.lo      = lo;
            r.dport   = prt;
            r.last    = last;
            awaited_replies.push_back(r);
        endfunction

        function void note_request(logic [2:0] op, logic [23:0] va, logic [63:0] hi,
                                   logic [63:0] lo, logic [15:0] prt, logic [15:0] ttl);
            int     pick;
            int     n;
            bit     member;
            t_reply tail;
            case (op)
                fdt_pkg::OP_TICK: seconds_now = seconds_now + 32'd1;
                fdt_pkg::OP_REGISTER: begin
                    if (!accepting) begin
                        await_reply(fdt_pkg::RC_REG_NAK, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                    end else begin
                        pick = -1;
                        // same address refreshes in place, live or not
                        for (int s = 0; s < fdt_pkg::TABLE_ENTRIES && pick < 0; s++)
                            if (used[s] && vaddr[s] == va)
                                pick = s;
                        for (int s = 0; s < fdt_pkg::TABLE_ENTRIES && pick < 0; s++)
                            if (!is_live(s))
                                pick = s;
                        if (pick < 0) begin
                            await_reply(fdt_pkg::RC_FULL, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                        end else begin
                            used[pick]     = 1'b1;
                            vaddr[pick]    = va;
                            ip_high[pick]  = hi;
                            ip_low[pick]   = lo;
                            udp_port[pick] = prt;
                            lifetime[pick] = {1'b0, ttl} + 17'(fdt_pkg::GRACE_SECONDS);
                            stamp[pick]    = seconds_now;
                            await_reply(fdt_pkg::RC_OK, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                        end
                    end
                end
                fdt_pkg::OP_UNREGISTER: begin
                    if (!accepting) begin
                        await_reply(fdt_pkg::RC_DEL_NAK, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                    end else begin
                        pick = -1;
                        for (int s = 0; s < fdt_pkg::TABLE_ENTRIES && pick < 0; s++)
                            if (used[s] && vaddr[s] == va && ip_high[s] == hi &&
                                ip_low[s] == lo && udp_port[s] == prt)
                                pick = s;
                        if (pick < 0) begin
                            await_reply(fdt_pkg::RC_NOT_FOUND, 1'b0, 1'b0, '0, '0, '0,
                                        1'b1);
                        end else begin
                            used[pick] = 1'b0;
                            await_reply(fdt_pkg::RC_OK, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                        end
                    end
                end
                fdt_pkg::OP_QUERY: begin
                    member = 1'b0;
                    for (int s = 0; s < fdt_pkg::TABLE_ENTRIES; s++)
                        if (is_live(s) && vaddr[s] == va)
                            member = 1'b1;
                    await_reply(fdt_pkg::RC_OK, member, 1'b0, '0, '0, '0, 1'b1);
                end
                fdt_pkg::OP_DISTRIBUTE: begin
                    n = 0;
                    for (int s = 0; s < fdt_pkg::TABLE_ENTRIES && n < fdt_pkg::RESULT_LIMIT;
                         s++)
                        if (is_live(s) && vaddr[s] != va) begin
                            await_reply(fdt_pkg::RC_OK, 1'b0, 1'b1, ip_high[s], ip_low[s],
                                        udp_port[s], 1'b0);
                            n++;
                        end
                    if (n == 0) begin
                        await_reply(fdt_pkg::RC_OK, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                    end else begin
                        tail = awaited_replies.pop_back();
                        tail.last = 1'b1;
                        awaited_replies.push_back(tail);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s expected %0h got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                $error("result item with no request pending");
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            compare("result_code", 64'(want.code), 64'(got.code));
            compare("is_member", 64'(want.member), 64'(got.member));
            compare("entry_present", 64'(want.present), 64'(got.present));
            compare("dest_addr_high", want.hi, got.hi);
            compare("dest_addr_low", want.lo, got.lo);
            compare("dest_port", 64'(want.dport), 64'(got.dport));
            compare("last", 64'(want.last), 64'(got.last));
        endfunction

        function int awaited();
            return awaited_replies.size();
        endfunction

        // copy of one slot, so unregister can aim at what is really stored
        function bit slot_tuple(int s, output logic [23:0] va, output logic [63:0] hi,
                                output logic [63:0] lo, output logic [15:0] prt);
            va  = vaddr[s];
            hi  = ip_high[s];
            lo  = ip_low[s];
            prt = udp_port[s];
            return used[s];
        endfunction
    endclass

    // clock, reset and block signals, the driven ones known from time zero
    logic        i_clk       = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [2:0]  in_operation = '0;
    logic [23:0] in_vaddr     = '0;
    logic [63:0] in_addr_high = '0;
    logic [63:0] in_addr_low  = '0;
    logic [15:0] in_port      = '0;
    logic [15:0] in_ttl       = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [2:0]  res_code;
    logic        res_member;
    logic        res_present;
    logic [63:0] res_addr_high;
    logic [63:0] res_addr_low;
    logic [15:0] res_port;
    logic        res_last;

    t_reply_board board;

    // known devices: each address with its own ip and port
    logic [23:0] pool_va   [POOL_SIZE];
    logic [63:0] pool_hi   [POOL_SIZE];
    logic [63:0] pool_lo   [POOL_SIZE];
    logic [15:0] pool_port [POOL_SIZE];

    int burst_left   = 3;
    int replies_seen = 0;
    int hold_left    = 0;
    int pattern_age  = 0;
    int stall_pct    = 0;
    int idle_cycles  = 0;

    foreign_device_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_wr_data     (cfg_wr_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (in_operation),
        .i_virtual_address (in_vaddr),
        .i_addr_high       (in_addr_high),
        .i_addr_low        (in_addr_low),
        .i_port            (in_port),
        .i_time_to_live    (in_ttl),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_result_code     (res_code),
        .o_is_member       (res_member),
        .o_entry_present   (res_present),
        .o_dest_addr_high  (res_addr_high),
        .o_dest_addr_low   (res_addr_low),
        .o_dest_port       (res_port),
        .o_last            (res_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly random, with the all-zero and all-one corners now and then
    function automatic logic [63:0] rand64();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // short lifetimes dominate so that entries expire within a few tick bursts
    function automatic logic [15:0] rand_ttl();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return 16'($urandom_range(12));
        if (r < 70)
            return 16'($urandom_range(400, 13));
        if (r < 90)
            return 16'($urandom);
        if (r < 95)
            return 16'hFFFF;
        return 16'h0000;
    endfunction

    // offer one item, wait for the handshake, then maybe idle before the next one;
    // valid stays high across a burst so back-to-back items never toggle it
    task automatic send_request(input logic [2:0] op, input logic [23:0] va,
                                input logic [63:0] hi, input logic [63:0] lo,
                                input logic [15:0] prt, input logic [15:0] ttl);
        int gap;
        in_valid     <= 1'b1;
        in_operation <= op;
        in_vaddr     <= va;
        in_addr_high <= hi;
        in_addr_low  <= lo;
        in_port      <= prt;
        in_ttl       <= ttl;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        board.note_request(op, va, hi, lo, prt, ttl);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(99);
            if (gap < 35)
                gap = 0;
            else if (gap < 85)
                gap = $urandom_range(4, 1);
            else
                gap = $urandom_range(30, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // an occasional long burst gives stretches with no idling
            burst_left = ($urandom_range(99) < 15) ? $urandom_range(40, 20)
                                                    : $urandom_range(6, 1);
        end
    endtask

    // config writes only land when the block is idle: no reply owed, and a
    // settling wait after that
    task automatic set_accept(input bit enable);
        in_valid <= 1'b0;
        while (board.awaited() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= enable;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        board.accepting = enable;
    endtask

    // random traffic of about ops items: mostly well-formed requests on known
    // devices, plus tick bursts to age entries, registration storms to fill the
    // table, and noise (unknown addresses, near-miss unregisters, spare codes)
    task automatic run_traffic(input int ops);
        int          done;
        int          kind;
        int          pick;
        int          d;
        int          s;
        logic [2:0]  op;
        logic [23:0] va;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] prt;
        logic [15:0] ttl;
        done = 0;
        while (done < ops) begin
            kind = $urandom_range(99);
            d    = $urandom_range(POOL_SIZE - 1);
            va   = pool_va[d];
            hi   = pool_hi[d];
            lo   = pool_lo[d];
            prt  = pool_port[d];
            ttl  = rand_ttl();
            if (kind < 6) begin
                // tick fields are don't-care, keep them busy anyway
                repeat ($urandom_range(35, 5)) begin
                    send_request(fdt_pkg::OP_TICK, 24'($urandom), rand64(), rand64(),
                                 16'($urandom), 16'($urandom));
                    done++;
                end
            end else if (kind < 12) begin
                // storm of long-lived registrations drives the table full
                repeat ($urandom_range(12, 6)) begin
                    d = $urandom_range(POOL_SIZE - 1);
                    send_request(fdt_pkg::OP_REGISTER, pool_va[d], pool_hi[d], pool_lo[d],
                                 pool_port[d], 16'($urandom_range(65535, 200)));
                    done++;
                end
            end else if (kind < 15) begin
                send_request(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                             24'($urandom), rand64(), rand64(), 16'($urandom),
                             16'($urandom));
                done++;
            end else begin
                if (kind < 42) begin
                    op   = fdt_pkg::OP_REGISTER;
                    pick = $urandom_range(19);
                    if (pick == 0) begin
                        va = 24'($urandom);
                    end else if (pick < 4) begin
                        // known address moving to a new ip and port
                        hi  = rand64();
                        lo  = rand64();
                        prt = 16'($urandom);
                    end
                end else if (kind < 58) begin
                    op   = fdt_pkg::OP_UNREGISTER;
                    pick = $urandom_range(19);
                    s    = $urandom_range(fdt_pkg::TABLE_ENTRIES - 1);
                    if (pick < 8) begin
                        void'(board.slot_tuple(s, va, hi, lo, prt));
                    end else if (pick < 11) begin
                        prt = prt ^ 16'h0001;
                    end else if (pick < 13) begin
                        hi = hi ^ (64'd1 << $urandom_range(63));
                    end else if (pick < 15) begin
                        lo = lo ^ (64'd1 << $urandom_range(63));
                    end else if (pick < 17) begin
                        va  = 24'($urandom);
                        hi  = rand64();
                        lo  = rand64();
                        prt = 16'($urandom);
                    end
                end else if (kind < 78) begin
                    op = fdt_pkg::OP_QUERY;
                    if ($urandom_range(4) == 0)
                        va = 24'($urandom);
                end else begin
                    op = fdt_pkg::OP_DISTRIBUTE;
                    if ($urandom_range(2) == 0)
                        va = 24'($urandom);
                end
                send_request(op, va, hi, lo, prt, ttl);
                done++;
            end
        end
    endtask

    // result side: check each accepted result, then pick the next stall value;
    // a new stall percentage is drawn each time the current pattern ages out, and
    // once every 80 results the receiver holds off long enough for the block to back up its input
    always @(posedge i_clk) begin : reply_side
        t_reply got;
        if (out_valid && !out_stall) begin
            got.code    = res_code;
            got.member  = res_member;
            got.present = res_present;
            got.hi      = res_addr_high;
            got.lo      = res_addr_low;
            got.dport   = res_port;
            got.last    = res_last;
            board.check_reply(got);
            replies_seen++;
            if (replies_seen % 80 == 40)
                hold_left = HOLD_CYCLES;
        end
        if (pattern_age <= 0) begin
            pattern_age = $urandom_range(80, 20);
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
        end
        pattern_age--;
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        board = new();
        for (int d = 0; d < POOL_SIZE; d++) begin
            pool_va[d]   = 24'($urandom);
            pool_hi[d]   = {$urandom, $urandom};
            pool_lo[d]   = {$urandom, $urandom};
            pool_port[d] = 16'($urandom);
        end
        // keep the address corners among the known devices
        pool_va[0] = 24'h000000;
        pool_va[1] = 24'hFFFFFF;

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // registrations still off after reset: naks, empty answers, dropped codes
        send_request(fdt_pkg::OP_REGISTER, 24'h000000, '0, '0, '0, '0);
        send_request(fdt_pkg::OP_UNREGISTER, 24'hFFFFFF, '1, '1, '1, '1);
        send_request(fdt_pkg::OP_QUERY, 24'hFFFFFF, '0, '0, '0, '0);
        send_request(fdt_pkg::OP_DISTRIBUTE, 24'h000000, '1, '1, '1, '1);
        send_request(OP_SPARE_FIRST, 24'h000000, '0, '0, '0, '0);
        send_request(OP_SPARE_LAST, 24'hFFFFFF, '1, '1, '1, '1);

        set_accept(1'b1);
        // field corners, then a refresh of an existing address
        send_request(fdt_pkg::OP_REGISTER, 24'h000000, '0, '0, '0, 16'h0000);
        send_request(fdt_pkg::OP_REGISTER, 24'hFFFFFF, '1, '1, '1, 16'hFFFF);
        send_request(fdt_pkg::OP_REGISTER, pool_va[2], pool_hi[2], pool_lo[2],
                     pool_port[2], 16'd100);
        send_request(fdt_pkg::OP_REGISTER, 24'h000000, pool_hi[3], pool_lo[3],
                     pool_port[3], 16'd5);
        send_request(fdt_pkg::OP_QUERY, 24'h000000, '0, '0, '0, '0);
        send_request(fdt_pkg::OP_QUERY, pool_va[4], '0, '0, '0, '0);
        // distribute excluding a member, and with a source outside the table
        send_request(fdt_pkg::OP_DISTRIBUTE, 24'hFFFFFF, '0, '0, '0, '0);
        send_request(fdt_pkg::OP_DISTRIBUTE, pool_va[5], '0, '0, '0, '0);
        // unregister near miss on the port, then the exact entry
        send_request(fdt_pkg::OP_UNREGISTER, 24'hFFFFFF, '1, '1, 16'hFFFE, '0);
        send_request(fdt_pkg::OP_UNREGISTER, 24'hFFFFFF, '1, '1, '1, '0);
        send_request(fdt_pkg::OP_TICK, 24'hFFFFFF, '1, '1, '1, '1);
        send_request(fdt_pkg::OP_DISTRIBUTE, 24'hFFFFFF, '0, '0, '0, '0);
        send_request(OP_SPARE_FIRST + 3'd1, 24'h123456, '0, '1, '0, '1);
        send_request(fdt_pkg::OP_QUERY, 24'hFFFFFF, '0, '0, '0, '0);

        run_traffic(100);
        // disabled again: register and unregister nak, query and distribute still work
        set_accept(1'b0);
        run_traffic(30);
        set_accept(1'b1);
        run_traffic(50);

        in_valid <= 1'b0;
        while (board.awaited() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES + 16) @(posedge i_clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/fdt_pkg.sv
rtl/fdt_ctrl.sv
rtl/fdt_datapath.sv
rtl/foreign_device_table.sv
rtl/fdt_checker.sv
bench/foreign_device_table_test.sv
